// ----- rtl/ptrs_pkg.sv -----
package ptrs_pkg;

  // Default table depth
  localparam int TASKS_DEF = 8;
  // Releases one tick may produce at most
  localparam int MAX_RES = 8;
  localparam int CNT_W = 4;

  localparam int TIME_W = 32;
  localparam int PER_W = 16;
  localparam int PHASE_W = 16;
  localparam int OIDX_W = 3;
  localparam int KIND_W = 2;
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 40;

  // Result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_RELEASE = 2'd0,
    KIND_REG_OK = 2'd1,
    KIND_REJ_FULL = 2'd2,
    KIND_REJ_ZERO = 2'd3
  } kind_t;

  // Input beat kinds
  localparam logic MODE_REGISTER = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // One result beat, less tlast
  typedef struct packed {
    kind_t kind;
    logic [OIDX_W-1:0] idx;
    logic [TIME_W-1:0] rtime;
  } res_t;

  // Shared compare/add unit results
  typedef struct packed {
    logic due;
    logic [TIME_W-1:0] nrl_sum;
  } alu_res_t;

endpackage

// ----- rtl/ptrs_table.sv -----
module ptrs_table import ptrs_pkg::*; #(
  parameter int TASKS = TASKS_DEF,
  parameter int IW = (TASKS > 1) ? $clog2(TASKS) : 1
) (
  input  logic              clk,
  input  logic              wr_per_en,
  input  logic              wr_nrl_en,
  input  logic [IW-1:0]     wr_addr,
  input  logic [PER_W-1:0]  wr_per,
  input  logic [TIME_W-1:0] wr_nrl,
  input  logic              rd_en,
  input  logic [IW-1:0]     rd_addr,
  output logic [PER_W-1:0]  rd_per,
  output logic [TIME_W-1:0] rd_nrl
);

  logic [PER_W-1:0]  per_mem [TASKS];
  logic [TIME_W-1:0] nrl_mem [TASKS];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_per_en) begin
      per_mem[wr_addr] <= wr_per;
    end
    if (wr_nrl_en) begin
      nrl_mem[wr_addr] <= wr_nrl;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_per <= per_mem[rd_addr];
      rd_nrl <= nrl_mem[rd_addr];
    end
  end

endmodule

// ----- rtl/ptrs_alu.sv -----
module ptrs_alu import ptrs_pkg::*; (
  input  logic [TIME_W-1:0] now,
  input  logic [TIME_W-1:0] nrl,
  input  logic [PER_W-1:0]  per,
  output alu_res_t          res
);

  logic [TIME_W-1:0] diff;

  // Due when (now - next release) is non-negative as a signed word
  always_comb begin
    diff = now - nrl;
    res.due = ~diff[TIME_W-1];
    res.nrl_sum = nrl + TIME_W'(per);
  end

endmodule

// ----- rtl/periodic_task_release_scheduler.sv -----
// Register beat: one result, out_tvalid raised in the cycle after acceptance.
// Tick beat: ST_READ fetches entry 0, ST_EVAL checks the tasks in turn and ST_FLUSH
// sends the last release; with no tasks registered, a tick only advances time.
// A tick may stall while a release waits on out_tready; in_tready is low all scan.
// rst_n (synchronous, active low) clears time, task count and control state.
module periodic_task_release_scheduler import ptrs_pkg::*; #(
  parameter int TASKS = TASKS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // period[15:0], phase_offset[31:16]
  input  logic                  in_tuser,   // mode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // task_index[2:0], release_time[34:3], 0
  output logic [KIND_W-1:0]     out_tuser,  // kind
  output logic                  out_tlast
);

  localparam int IW = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int TW = $clog2(TASKS + 1);
  localparam logic [TW-1:0] TOTAL_MAX = TW'(TASKS);
  localparam logic [CNT_W-1:0] LAST_RES = CNT_W'(MAX_RES - 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_READ  = 4'b0010,
    ST_EVAL  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;
  logic [TW-1:0]     total_r, total_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              pend_vld_r, pend_vld_nxt;
  res_t              pend_r, pend_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic              out_last_r, out_last_nxt;
  res_t              out_r, out_nxt;

  logic              wr_per_en, wr_nrl_en;
  logic [IW-1:0]     wr_addr;
  logic [TIME_W-1:0] wr_nrl;
  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  logic [PER_W-1:0]  rd_per;
  logic [TIME_W-1:0] rd_nrl;
  alu_res_t          alu;

  logic              out_free;
  logic              in_acc;
  logic [PER_W-1:0]  in_period;
  logic [PHASE_W-1:0] in_phase;
  logic              scan_end;

  ptrs_table #(.TASKS(TASKS), .IW(IW)) u_table (
    .clk       (clk),
    .wr_per_en (wr_per_en),
    .wr_nrl_en (wr_nrl_en),
    .wr_addr   (wr_addr),
    .wr_per    (in_period),
    .wr_nrl    (wr_nrl),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_per    (rd_per),
    .rd_nrl    (rd_nrl)
  );

  ptrs_alu u_alu (
    .now (time_r),
    .nrl (rd_nrl),
    .per (rd_per),
    .res (alu)
  );

  assign in_period = in_tdata[PER_W-1:0];
  assign in_phase  = in_tdata[PER_W +: PHASE_W];
  assign out_free  = ~out_vld_r | out_tready;
  assign in_tready = (state_r == ST_IDLE) & out_free;
  assign in_acc    = in_tvalid & in_tready;

  // Scan stops on the last task or once the release budget is used
  assign scan_end = (TW'(idx_r) == total_r - TW'(1)) | (alu.due & (cnt_r == LAST_RES));

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    time_nxt     = time_r;
    total_nxt    = total_r;
    idx_nxt      = idx_r;
    cnt_nxt      = cnt_r;
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    out_vld_nxt  = out_vld_r & ~out_tready;
    out_last_nxt = out_last_r;
    out_nxt      = out_r;
    wr_per_en    = 1'b0;
    wr_nrl_en    = 1'b0;
    wr_addr      = idx_r;
    wr_nrl       = alu.nrl_sum;
    rd_en        = 1'b0;
    rd_addr      = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == MODE_REGISTER) begin
            out_vld_nxt   = 1'b1;
            out_last_nxt  = 1'b1;
            out_nxt.idx   = '0;
            out_nxt.rtime = '0;
            if (total_r == TOTAL_MAX) begin
              out_nxt.kind = KIND_REJ_FULL;
            end else if (in_period == '0) begin
              out_nxt.kind = KIND_REJ_ZERO;
            end else begin
              out_nxt.kind = KIND_REG_OK;
              out_nxt.idx  = OIDX_W'(total_r);
              wr_per_en    = 1'b1;
              wr_nrl_en    = 1'b1;
              wr_addr      = IW'(total_r);
              wr_nrl       = TIME_W'(in_phase);
              total_nxt    = total_r + TW'(1);
            end
          end else if (total_r == '0) begin
            time_nxt = time_r + TIME_W'(1);
          end else begin
            idx_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        rd_en     = 1'b1;
        rd_addr   = idx_r;
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        // Hold while a second release needs the busy output register
        if (!(alu.due && pend_vld_r && !out_free)) begin
          if (alu.due) begin
            if (pend_vld_r) begin
              out_vld_nxt  = 1'b1;
              out_last_nxt = 1'b0;
              out_nxt      = pend_r;
            end
            pend_vld_nxt   = 1'b1;
            pend_nxt.kind  = KIND_RELEASE;
            pend_nxt.idx   = OIDX_W'(idx_r);
            pend_nxt.rtime = time_r;
            wr_nrl_en      = 1'b1;
            cnt_nxt        = cnt_r + CNT_W'(1);
          end
          if (scan_end) begin
            state_nxt = ST_FLUSH;
          end else begin
            idx_nxt = IW'(idx_r + IW'(1));
            rd_en   = 1'b1;
            rd_addr = IW'(idx_r + IW'(1));
          end
        end
      end
      ST_FLUSH: begin
        // Final release, if any, goes out with tlast, then time advances
        if (!pend_vld_r) begin
          time_nxt  = time_r + TIME_W'(1);
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_last_nxt = 1'b1;
          out_nxt      = pend_r;
          pend_vld_nxt = 1'b0;
          time_nxt     = time_r + TIME_W'(1);
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      time_r     <= '0;
      total_r    <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      time_r     <= time_nxt;
      total_r    <= total_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // Payload and scan position
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    cnt_r      <= cnt_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(OUT_DATA_W - TIME_W - OIDX_W)'(0), out_r.rtime, out_r.idx};
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_last_r;

  // Checks
  a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_vld_r)
    else $error("release held back while idle");

  a_total_max: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= TOTAL_MAX)
    else $error("task count beyond table depth");

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVAL) |-> (cnt_r < CNT_W'(MAX_RES)))
    else $error("release budget exceeded during scan");

  a_time_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVAL) |=> (time_r == $past(time_r)))
    else $error("time moved during a scan");

endmodule
